// ===== hw/rtl/slss_pkg.sv =====
// Shared types and constants for the speed-triggered logging start/stop block.
package slss_pkg;

  localparam int unsigned DELAY_W = 18;               // delay in ms, up to 255000
  localparam logic [DELAY_W-1:0] MS_PER_S = 18'd1000;
  // Reciprocal of 1000 scaled by 2^28, rounded up; exact below 2^18 / 1000.
  localparam logic [18:0] RECIP_1000 = 19'd268436;
  localparam int unsigned RECIP_SHIFT = 28;
  localparam logic [15:0] CENTI_PER_KMH = 16'd100;

  typedef enum logic [2:0] {
    REG_AUTO_LOG_ENABLE     = 3'd0,
    REG_START_SPEED_KMH     = 3'd1,
    REG_STOP_SPEED_KMH      = 3'd2,
    REG_START_DELAY_S       = 3'd3,
    REG_STOP_DELAY_S        = 3'd4,
    REG_TRIP_RESET_ON_START = 3'd5
  } slss_reg_t;

  typedef struct packed {
    logic       auto_log_enable;
    logic [7:0] start_speed_kmh;
    logic [7:0] stop_speed_kmh;
    logic [7:0] start_delay_s;
    logic [7:0] stop_delay_s;
    logic       trip_reset_on_start;
  } slss_cfg_t;

  typedef struct packed {
    logic        opcode;
    logic [15:0] speed_centi_kmh;
    logic        has_fix;
    logic [31:0] now_ms;
    logic        manual_on;
  } slss_in_t;

  typedef struct packed {
    logic       logging_on;
    logic       auto_started;
    logic       auto_stopped;
    logic       trip_reset;
    logic       armed;
    logic [8:0] stop_countdown_s;
  } slss_out_t;

endpackage

// ===== hw/rtl/slss_cfg_regs.sv =====
// Configuration register file for the logging start/stop block.
module slss_cfg_regs
  import slss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [7:0] wr_data,
  output slss_cfg_t  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.auto_log_enable     <= 1'b0;
      cfg.start_speed_kmh     <= 8'd10;
      cfg.stop_speed_kmh      <= 8'd5;
      cfg.start_delay_s       <= 8'd10;
      cfg.stop_delay_s        <= 8'd60;
      cfg.trip_reset_on_start <= 1'b0;
    end else if (wr_en) begin
      case (slss_reg_t'(wr_index))
        REG_AUTO_LOG_ENABLE:     cfg.auto_log_enable     <= wr_data[0];
        REG_START_SPEED_KMH:     cfg.start_speed_kmh     <= wr_data;
        REG_STOP_SPEED_KMH:      cfg.stop_speed_kmh      <= wr_data;
        REG_START_DELAY_S:       cfg.start_delay_s       <= wr_data;
        REG_STOP_DELAY_S:        cfg.stop_delay_s        <= wr_data;
        REG_TRIP_RESET_ON_START: cfg.trip_reset_on_start <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/slss_step.sv =====
// Logging state, dwell timers, hold flag and per-item result logic.
module slss_step
  import slss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  slss_cfg_t cfg,
  input  slss_in_t  item,
  output slss_out_t result
);

  logic        logging_active, logging_active_next;
  logic [31:0] above_start_time, above_start_time_next;
  logic        above_timer_valid, above_timer_valid_next;
  logic [31:0] below_start_time, below_start_time_next;
  logic        below_timer_valid, below_timer_valid_next;
  logic        manual_hold, manual_hold_next;

  logic [15:0]        speed;
  logic [7:0]         start_m1;
  logic [7:0]         eff_stop_kmh;
  logic [15:0]        eff_stop_centi;
  logic [15:0]        start_centi;
  logic               above_stop;
  logic               at_start;
  logic [31:0]        above_elapsed;
  logic [31:0]        below_elapsed;
  logic [DELAY_W-1:0] start_total;
  logic [DELAY_W-1:0] stop_total;
  logic               above_fire;
  logic               below_fire;
  logic               started, stopped, trip;
  logic [DELAY_W-1:0] remain_ms;
  logic [36:0]        remain_prod;
  logic [7:0]         remain_s;

  always_comb begin
    speed          = item.has_fix ? item.speed_centi_kmh : 16'd0;
    start_m1       = cfg.start_speed_kmh - 8'd1;
    eff_stop_kmh   = (cfg.stop_speed_kmh < start_m1) ? cfg.stop_speed_kmh : start_m1;
    eff_stop_centi = 16'({8'd0, eff_stop_kmh} * CENTI_PER_KMH);
    start_centi    = 16'({8'd0, cfg.start_speed_kmh} * CENTI_PER_KMH);
    // start speed zero puts the stop threshold below zero
    above_stop     = (cfg.start_speed_kmh == 8'd0) || (speed > eff_stop_centi);
    at_start       = speed >= start_centi;

    start_total    = DELAY_W'({10'd0, cfg.start_delay_s} * MS_PER_S);
    stop_total     = DELAY_W'({10'd0, cfg.stop_delay_s} * MS_PER_S);
    // a timer that is not running yet starts at this item's time
    above_elapsed  = above_timer_valid ? (item.now_ms - above_start_time) : 32'd0;
    below_elapsed  = below_timer_valid ? (item.now_ms - below_start_time) : 32'd0;
    above_fire     = above_elapsed >= {14'd0, start_total};
    below_fire     = below_elapsed >= {14'd0, stop_total};
  end

  always_comb begin
    logging_active_next    = logging_active;
    above_start_time_next  = above_start_time;
    above_timer_valid_next = above_timer_valid;
    below_start_time_next  = below_start_time;
    below_timer_valid_next = below_timer_valid;
    manual_hold_next       = manual_hold;
    started                = 1'b0;
    stopped                = 1'b0;
    trip                   = 1'b0;

    if (item.opcode) begin
      logging_active_next    = item.manual_on;
      above_timer_valid_next = 1'b0;
      below_timer_valid_next = 1'b0;
      manual_hold_next       = !item.manual_on && above_stop;
    end else if (!cfg.auto_log_enable) begin
      above_timer_valid_next = 1'b0;
      below_timer_valid_next = 1'b0;
      manual_hold_next       = 1'b0;
    end else if (logging_active) begin
      above_timer_valid_next = 1'b0;
      if (above_stop) begin
        below_timer_valid_next = 1'b0;
      end else if (below_fire) begin
        below_timer_valid_next = 1'b0;
        manual_hold_next       = 1'b0;
        logging_active_next    = 1'b0;
        stopped                = 1'b1;
      end else if (!below_timer_valid) begin
        below_start_time_next  = item.now_ms;
        below_timer_valid_next = 1'b1;
      end
    end else begin
      below_timer_valid_next = 1'b0;
      manual_hold_next       = manual_hold && above_stop;
      if (manual_hold_next || !at_start) begin
        above_timer_valid_next = 1'b0;
      end else if (above_fire) begin
        above_timer_valid_next = 1'b0;
        trip                   = cfg.trip_reset_on_start;
        logging_active_next    = 1'b1;
        started                = 1'b1;
      end else if (!above_timer_valid) begin
        above_start_time_next  = item.now_ms;
        above_timer_valid_next = 1'b1;
      end
    end
  end

  // Countdown: remaining ms divided by 1000 through the scaled reciprocal.
  always_comb begin
    remain_ms   = stop_total - below_elapsed[DELAY_W-1:0];
    remain_prod = {19'd0, remain_ms} * {18'd0, RECIP_1000};
    remain_s    = remain_prod[RECIP_SHIFT +: 8];

    result.logging_on       = logging_active_next;
    result.auto_started     = started;
    result.auto_stopped     = stopped;
    result.trip_reset       = trip;
    result.armed            = cfg.auto_log_enable && !logging_active_next;
    result.stop_countdown_s = below_timer_valid_next ? ({1'b0, remain_s} + 9'd1) : 9'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      logging_active    <= 1'b0;
      above_timer_valid <= 1'b0;
      below_timer_valid <= 1'b0;
      manual_hold       <= 1'b0;
    end else if (step) begin
      logging_active    <= logging_active_next;
      above_timer_valid <= above_timer_valid_next;
      below_timer_valid <= below_timer_valid_next;
      manual_hold       <= manual_hold_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      above_start_time <= above_start_time_next;
      below_start_time <= below_start_time_next;
    end
  end

endmodule

// ===== hw/rtl/speed_triggered_log_start_stop.sv =====
// Top level of the speed-triggered logging start/stop controller.
// Flow: an accepted item is held in the input register, then moves into the
// result register once that register is free or being drained, then can be taken.
// Throughput: one item per cycle while out_ready stays high; the dwell-timer
// compare and the countdown reciprocal multiply sit between the two registers.
// Reset (rst, synchronous): logging off, both timers idle, hold clear,
// configuration back to its defaults, both registers empty.
module speed_triggered_log_start_stop
  import slss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  slss_in_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output slss_out_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);

  slss_cfg_t cfg;
  slss_in_t  hold_item;     // input register
  logic      hold_valid;
  slss_out_t step_result;
  logic      advance;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  slss_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Move the held item into the result register whenever that register is
  // free or being drained; the state update happens on the same edge.
  assign advance  = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_data;
    end
  end

  slss_step u_step (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .cfg    (cfg),
    .item   (hold_item),
    .result (step_result)
  );

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= step_result;
    end
  end

endmodule
